// File: rtl/core/sct_pkg.sv
// Shared types, widths and decision codes of the segment crossing test unit.
package sct_pkg;

    // Coordinate width and the widths that grow out of it
    localparam int CW = 16;              // one coordinate
    localparam int DW = CW + 1;          // difference of two coordinates
    localparam int PW = 2 * DW;          // product of two differences
    localparam int SW = PW + 1;          // sum of two such products
    localparam int FW = SW + DW;         // scaled ordinate times a run
    localparam int GW = FW + 1;          // difference of two scaled ordinates

    // Stages from input register to output register
    localparam int PIPE_DEPTH = 6;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    // Which branch decided the answer
    localparam logic [2:0] DEC_DISJOINT  = 3'd0;
    localparam logic [2:0] DEC_A_VERT    = 3'd1;
    localparam logic [2:0] DEC_B_VERT    = 3'd2;
    localparam logic [2:0] DEC_GENERAL   = 3'd3;
    localparam logic [2:0] DEC_PARALLEL  = 3'd4;
    localparam logic [2:0] DEC_BOTH_VERT = 3'd5;

    // One input item: two segments
    typedef struct packed {
        logic signed [CW-1:0] ax0;
        logic signed [CW-1:0] ay0;
        logic signed [CW-1:0] ax1;
        logic signed [CW-1:0] ay1;
        logic signed [CW-1:0] bx0;
        logic signed [CW-1:0] by0;
        logic signed [CW-1:0] bx1;
        logic signed [CW-1:0] by1;
    } sct_in_t;

    // One result item
    typedef struct packed {
        logic       crossed;
        logic [2:0] decided_by;
    } sct_out_t;

    // Load enables of the stages inside the line comparator
    typedef struct packed {
        logic ld3;
        logic ld4;
        logic ld5;
    } sct_stage_en_t;

    // Sign-extend a coordinate by one bit
    function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
        return {v[CW-1], v};
    endfunction

endpackage

// File: rtl/core/sct_lincmp.sv
// Three-stage exact comparison of two non-vertical lines at one abscissa.
module sct_lincmp
    import sct_pkg::*;
(
    input  logic                 aclk,
    input  sct_stage_en_t        en,
    input  logic signed [CW-1:0] y0a,
    input  logic signed [DW-1:0] dxa,
    input  logic signed [DW-1:0] dya,
    input  logic signed [DW-1:0] offa,
    input  logic signed [CW-1:0] y0b,
    input  logic signed [DW-1:0] dxb,
    input  logic signed [DW-1:0] dyb,
    input  logic signed [DW-1:0] offb,
    output logic                 f_neg,
    output logic                 f_zero
);

    logic signed [PW-1:0] pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic signed [PW-1:0] pa0_next, pa1_next, pb0_next, pb1_next;
    logic signed [DW-1:0] dxa3_reg, dxb3_reg, dxa4_reg, dxb4_reg;
    logic signed [SW-1:0] na_reg, nb_reg, na_next, nb_next;
    logic signed [FW-1:0] fa_reg, fb_reg, fa_next, fb_next;
    logic signed [GW-1:0] diff;

    // Form the partial products of each scaled ordinate
    always_comb begin
        pa0_next = PW'(y0a) * PW'(dxa);
        pa1_next = PW'(dya) * PW'(offa);
        pb0_next = PW'(y0b) * PW'(dxb);
        pb1_next = PW'(dyb) * PW'(offb);
    end

    // Sum them: na/dxa and nb/dxb are the two ordinates
    always_comb begin
        na_next = SW'(pa0_reg) + SW'(pa1_reg);
        nb_next = SW'(pb0_reg) + SW'(pb1_reg);
    end

    // Cross-multiply by the other run, both runs positive
    always_comb begin
        fa_next = FW'(na_reg) * FW'(dxb4_reg);
        fb_next = FW'(nb_reg) * FW'(dxa4_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.ld3) begin
            pa0_reg  <= pa0_next;
            pa1_reg  <= pa1_next;
            pb0_reg  <= pb0_next;
            pb1_reg  <= pb1_next;
            dxa3_reg <= dxa;
            dxb3_reg <= dxb;
        end
        if (en.ld4) begin
            na_reg   <= na_next;
            nb_reg   <= nb_next;
            dxa4_reg <= dxa3_reg;
            dxb4_reg <= dxb3_reg;
        end
        if (en.ld5) begin
            fa_reg <= fa_next;
            fb_reg <= fb_next;
        end
    end

    // Sign of line A minus line B
    assign diff   = GW'(fa_reg) - GW'(fb_reg);
    assign f_neg  = diff[GW-1];
    assign f_zero = (diff == '0);

endmodule

// File: rtl/core/segment_crossing_test_unit.sv
// Top level of the segment crossing test unit.
// Takes one pair of integer segments per item and returns whether they share a
// point, with a code naming the branch that decided it; parallel and doubly
// vertical pairs are always reported as not sharing one. All tests are exact
// cross-multiplications. The pipeline is six register stages deep, and a new
// item can be taken at every edge while m_ready does not stall the output.
// The depth is set by the two chained multiply stages needed for the general
// case (ordinate products, then cross-multiplication by the other run). Stalls
// on m_ready fill the bubbles first and then hold every stage; nothing is
// dropped or repeated.
module segment_crossing_test_unit
    import sct_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sct_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sct_out_t m_data
);

    // Stage valid bits and the ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !m_valid_reg || m_ready;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_ready = rdy1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg      <= s_valid;
            if (rdy2) v2_reg      <= v1_reg;
            if (rdy3) v3_reg      <= v2_reg;
            if (rdy4) v4_reg      <= v3_reg;
            if (rdy5) v5_reg      <= v4_reg;
            if (rdy6) m_valid_reg <= v5_reg;
        end
    end

    // ---------------- Stage 1: order each segment by x ----------------
    sct_in_t s1_seg_reg, s1_seg_next;

    always_comb begin
        s1_seg_next = s_data;
        if (s_data.ax1 < s_data.ax0) begin
            s1_seg_next.ax0 = s_data.ax1;
            s1_seg_next.ay0 = s_data.ay1;
            s1_seg_next.ax1 = s_data.ax0;
            s1_seg_next.ay1 = s_data.ay0;
        end
        if (s_data.bx1 < s_data.bx0) begin
            s1_seg_next.bx0 = s_data.bx1;
            s1_seg_next.by0 = s_data.by1;
            s1_seg_next.bx1 = s_data.bx0;
            s1_seg_next.by1 = s_data.by0;
        end
    end

    // ---------------- Stage 2: classify and take differences ----------------
    logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [CW-1:0] vx, vy0, vy1, px0, py0, px1, py1, ylo, yhi, xlo, xhi;

    logic [2:0]           s2_code_reg, s2_code_next;
    logic                 s2_inr_reg, s2_inr_next;
    logic                 s2_lohi_reg, s2_lohi_next;
    logic signed [DW-1:0] s2_dx_reg, s2_dx_next;
    logic signed [DW-1:0] s2_dpy_reg, s2_dpy_next;
    logic signed [DW-1:0] s2_vxoff_reg, s2_vxoff_next;
    logic signed [DW-1:0] s2_rlo_reg, s2_rlo_next;
    logic signed [DW-1:0] s2_rhi_reg, s2_rhi_next;
    logic signed [CW-1:0] s2_ay0_reg, s2_by0_reg;
    logic signed [DW-1:0] s2_dxa_reg, s2_dya_reg, s2_dxb_reg, s2_dyb_reg;
    logic signed [DW-1:0] s2_dxa_next, s2_dya_next, s2_dxb_next, s2_dyb_next;
    logic signed [DW-1:0] s2_loa_reg, s2_hia_reg, s2_lob_reg, s2_hib_reg;
    logic signed [DW-1:0] s2_loa_next, s2_hia_next, s2_lob_next, s2_hib_next;

    always_comb begin
        ax0 = s1_seg_reg.ax0;
        ay0 = s1_seg_reg.ay0;
        ax1 = s1_seg_reg.ax1;
        ay1 = s1_seg_reg.ay1;
        bx0 = s1_seg_reg.bx0;
        by0 = s1_seg_reg.by0;
        bx1 = s1_seg_reg.bx1;
        by1 = s1_seg_reg.by1;

        // Branch, in order of precedence
        priority if (ax1 < bx0) begin
            s2_code_next = DEC_DISJOINT;
        end else if (ax0 == ax1 && bx0 == bx1) begin
            s2_code_next = DEC_BOTH_VERT;
        end else if (ax0 == ax1) begin
            s2_code_next = DEC_A_VERT;
        end else if (bx0 == bx1) begin
            s2_code_next = DEC_B_VERT;
        end else begin
            s2_code_next = DEC_GENERAL;
        end

        // Pick the vertical segment and the segment it is tested against
        if (ax0 == ax1) begin
            vx  = ax0;
            vy0 = ay0;
            vy1 = ay1;
            px0 = bx0;
            py0 = by0;
            px1 = bx1;
            py1 = by1;
        end else begin
            vx  = bx0;
            vy0 = by0;
            vy1 = by1;
            px0 = ax0;
            py0 = ay0;
            px1 = ax1;
            py1 = ay1;
        end
        ylo = (vy0 < vy1) ? vy0 : vy1;
        yhi = (vy0 < vy1) ? vy1 : vy0;

        // Vertical test reduced to (ylo-py0)*dx <= dpy*(vx-px0) <= (yhi-py0)*dx
        s2_inr_next   = (px0 <= vx) && (vx <= px1);
        s2_dx_next    = sx(px1) - sx(px0);
        s2_dpy_next   = sx(py1) - sx(py0);
        s2_vxoff_next = sx(vx) - sx(px0);
        s2_rlo_next   = sx(ylo) - sx(py0);
        s2_rhi_next   = sx(yhi) - sx(py0);

        // General case: runs, rises and the overlap of the x ranges
        xlo = (ax0 > bx0) ? ax0 : bx0;
        xhi = (ax1 < bx1) ? ax1 : bx1;
        s2_lohi_next = (xlo <= xhi);
        s2_dxa_next  = sx(ax1) - sx(ax0);
        s2_dya_next  = sx(ay1) - sx(ay0);
        s2_dxb_next  = sx(bx1) - sx(bx0);
        s2_dyb_next  = sx(by1) - sx(by0);
        s2_loa_next  = sx(xlo) - sx(ax0);
        s2_hia_next  = sx(xhi) - sx(ax0);
        s2_lob_next  = sx(xlo) - sx(bx0);
        s2_hib_next  = sx(xhi) - sx(bx0);
    end

    // ---------------- Stage 3: products ----------------
    logic [2:0]           s3_code_reg;
    logic                 s3_inr_reg, s3_lohi_reg;
    logic signed [PW-1:0] s3_vl_reg, s3_vm_reg, s3_vh_reg, s3_pa_reg, s3_pb_reg;
    logic signed [PW-1:0] s3_vl_next, s3_vm_next, s3_vh_next, s3_pa_next, s3_pb_next;

    always_comb begin
        s3_vl_next = PW'(s2_rlo_reg) * PW'(s2_dx_reg);
        s3_vm_next = PW'(s2_dpy_reg) * PW'(s2_vxoff_reg);
        s3_vh_next = PW'(s2_rhi_reg) * PW'(s2_dx_reg);
        s3_pa_next = PW'(s2_dya_reg) * PW'(s2_dxb_reg);
        s3_pb_next = PW'(s2_dyb_reg) * PW'(s2_dxa_reg);
    end

    // ---------------- Stage 4: vertical hit and slope compare ----------------
    logic [2:0] s4_code_reg, s4_code_next;
    logic       s4_vhit_reg, s4_vhit_next;
    logic       s4_lohi_reg;

    always_comb begin
        s4_vhit_next = s3_inr_reg && (s3_vl_reg <= s3_vm_reg) && (s3_vm_reg <= s3_vh_reg);
        s4_code_next = s3_code_reg;
        if (s3_code_reg == DEC_GENERAL && s3_pa_reg == s3_pb_reg) begin
            s4_code_next = DEC_PARALLEL;
        end
    end

    // ---------------- Stage 5: carry flags past the cross-multiply ----------------
    logic [2:0] s5_code_reg;
    logic       s5_vhit_reg, s5_lohi_reg;

    // Line comparison at both ends of the x overlap (stages 3 to 5)
    sct_stage_en_t lc_en;
    logic          lo_neg, lo_zero, hi_neg, hi_zero;

    assign lc_en.ld3 = rdy3;
    assign lc_en.ld4 = rdy4;
    assign lc_en.ld5 = rdy5;

    sct_lincmp u_cmp_lo (
        .aclk   (aclk),
        .en     (lc_en),
        .y0a    (s2_ay0_reg),
        .dxa    (s2_dxa_reg),
        .dya    (s2_dya_reg),
        .offa   (s2_loa_reg),
        .y0b    (s2_by0_reg),
        .dxb    (s2_dxb_reg),
        .dyb    (s2_dyb_reg),
        .offb   (s2_lob_reg),
        .f_neg  (lo_neg),
        .f_zero (lo_zero)
    );

    sct_lincmp u_cmp_hi (
        .aclk   (aclk),
        .en     (lc_en),
        .y0a    (s2_ay0_reg),
        .dxa    (s2_dxa_reg),
        .dya    (s2_dya_reg),
        .offa   (s2_hia_reg),
        .y0b    (s2_by0_reg),
        .dxb    (s2_dxb_reg),
        .dyb    (s2_dyb_reg),
        .offb   (s2_hib_reg),
        .f_neg  (hi_neg),
        .f_zero (hi_zero)
    );

    // ---------------- Stage 6: result ----------------
    sct_out_t m_data_reg, m_data_next;

    always_comb begin
        m_data_next.decided_by = s5_code_reg;
        unique case (s5_code_reg)
            DEC_A_VERT, DEC_B_VERT: begin
                m_data_next.crossed = s5_vhit_reg;
            end
            DEC_GENERAL: begin
                // Lines swap order within the overlap, or touch at an end
                m_data_next.crossed = s5_lohi_reg &&
                                      (lo_zero || hi_zero || (lo_neg != hi_neg));
            end
            default: begin
                m_data_next.crossed = 1'b0;
            end
        endcase
    end

    assign m_data = m_data_reg;

    // Payload registers, advanced with their stage
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_seg_reg <= s1_seg_next;
        end
        if (rdy2) begin
            s2_code_reg  <= s2_code_next;
            s2_inr_reg   <= s2_inr_next;
            s2_lohi_reg  <= s2_lohi_next;
            s2_dx_reg    <= s2_dx_next;
            s2_dpy_reg   <= s2_dpy_next;
            s2_vxoff_reg <= s2_vxoff_next;
            s2_rlo_reg   <= s2_rlo_next;
            s2_rhi_reg   <= s2_rhi_next;
            s2_ay0_reg   <= ay0;
            s2_by0_reg   <= by0;
            s2_dxa_reg   <= s2_dxa_next;
            s2_dya_reg   <= s2_dya_next;
            s2_dxb_reg   <= s2_dxb_next;
            s2_dyb_reg   <= s2_dyb_next;
            s2_loa_reg   <= s2_loa_next;
            s2_hia_reg   <= s2_hia_next;
            s2_lob_reg   <= s2_lob_next;
            s2_hib_reg   <= s2_hib_next;
        end
        if (rdy3) begin
            s3_code_reg <= s2_code_reg;
            s3_inr_reg  <= s2_inr_reg;
            s3_lohi_reg <= s2_lohi_reg;
            s3_vl_reg   <= s3_vl_next;
            s3_vm_reg   <= s3_vm_next;
            s3_vh_reg   <= s3_vh_next;
            s3_pa_reg   <= s3_pa_next;
            s3_pb_reg   <= s3_pb_next;
        end
        if (rdy4) begin
            s4_code_reg <= s4_code_next;
            s4_vhit_reg <= s4_vhit_next;
            s4_lohi_reg <= s3_lohi_reg;
        end
        if (rdy5) begin
            s5_code_reg <= s4_code_reg;
            s5_vhit_reg <= s4_vhit_reg;
            s5_lohi_reg <= s4_lohi_reg;
        end
        if (rdy6) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// File: rtl/core/sct_checker.sv
// Port-level checker for the segment crossing test unit, bound to the top level.
module sct_checker
    import sct_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input sct_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input sct_out_t m_data
);

    logic             s_acc, m_acc;
    logic [CNT_W-1:0] inflight_reg, inflight_next;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // Count items taken in and not yet delivered
    always_comb begin
        inflight_next = inflight_reg;
        if (s_acc && !m_acc) begin
            inflight_next = inflight_reg + CNT_W'(1);
        end else if (m_acc && !s_acc) begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // Drop any result straight after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result shown after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or vanished");

    // Never invent a result
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result with no item in flight");

    // Never hold more items than stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    // Disjoint, parallel and doubly vertical pairs never cross
    a_no_cross: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.decided_by == DEC_DISJOINT ||
                    m_data.decided_by == DEC_PARALLEL ||
                    m_data.decided_by == DEC_BOTH_VERT) |-> !m_data.crossed)
        else $error("crossing reported by a branch that cannot cross");

endmodule

bind segment_crossing_test_unit sct_checker u_sct_checker (.*);

// File: test/tb_segment_crossing_test_unit.sv
// Self-checking testbench for the segment crossing test unit.
`timescale 1ns / 1ps

module tb_segment_crossing_test_unit;
    import sct_pkg::*;

    localparam int RANDOM_PAIRS = 1400;

    // One row of the directed table: a pair, and a verdict where it is known by eye
    typedef struct {
        sct_in_t  pair;
        bit       known;
        sct_out_t verdict;
    } probe_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sct_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sct_out_t m_data;

    sct_out_t   pending_verdicts[$];
    probe_row_t probe_table[$];
    int         mismatch_count = 0;
    int         burst_left     = 0;
    logic [31:0] ready_pattern = '1;
    logic [4:0]  ready_index   = '0;

    segment_crossing_test_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    task automatic flag_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Does the line through (px0,py0)-(px1,py1), px0 < px1, meet x = vx inside
    // the vertical span vy0..vy1 while vx lies within px0..px1
    function automatic bit meets_vertical(input longint vx, input longint vy0,
                                          input longint vy1, input longint px0,
                                          input longint py0, input longint px1,
                                          input longint py1);
        longint run, rise_at, ylo, yhi;
        run     = px1 - px0;
        rise_at = py0 * run + (py1 - py0) * (vx - px0);
        ylo     = (vy0 < vy1) ? vy0 : vy1;
        yhi     = (vy0 < vy1) ? vy1 : vy0;
        return (px0 <= vx) && (vx <= px1) && (ylo * run <= rise_at) && (rise_at <= yhi * run);
    endfunction

    // Work out the verdict for one pair, exactly, in 64-bit integers
    function automatic sct_out_t judge_segments(input sct_in_t p);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, t;
        longint dxa, dya, dxb, dyb, lo, hi, gap_lo, gap_hi;
        sct_out_t v;
        ax0 = $signed(p.ax0);
        ay0 = $signed(p.ay0);
        ax1 = $signed(p.ax1);
        ay1 = $signed(p.ay1);
        bx0 = $signed(p.bx0);
        by0 = $signed(p.by0);
        bx1 = $signed(p.bx1);
        by1 = $signed(p.by1);
        // order each segment left to right
        if (ax1 < ax0) begin
            t = ax0; ax0 = ax1; ax1 = t;
            t = ay0; ay0 = ay1; ay1 = t;
        end
        if (bx1 < bx0) begin
            t = bx0; bx0 = bx1; bx1 = t;
            t = by0; by0 = by1; by1 = t;
        end
        v.crossed = 1'b0;
        if (ax1 < bx0) begin
            v.decided_by = DEC_DISJOINT;
        end else if (ax0 == ax1 && bx0 == bx1) begin
            v.decided_by = DEC_BOTH_VERT;
        end else if (ax0 == ax1) begin
            v.decided_by = DEC_A_VERT;
            v.crossed    = meets_vertical(ax0, ay0, ay1, bx0, by0, bx1, by1);
        end else if (bx0 == bx1) begin
            v.decided_by = DEC_B_VERT;
            v.crossed    = meets_vertical(bx0, by0, by1, ax0, ay0, ax1, ay1);
        end else begin
            dxa = ax1 - ax0;
            dya = ay1 - ay0;
            dxb = bx1 - bx0;
            dyb = by1 - by0;
            if (dya * dxb == dyb * dxa) begin
                v.decided_by = DEC_PARALLEL;
            end else begin
                v.decided_by = DEC_GENERAL;
                lo = (ax0 > bx0) ? ax0 : bx0;
                hi = (ax1 < bx1) ? ax1 : bx1;
                if (lo <= hi) begin
                    // compare A's and B's heights at both ends of the shared x range
                    gap_lo = (ay0 * dxa + dya * (lo - ax0)) * dxb
                           - (by0 * dxb + dyb * (lo - bx0)) * dxa;
                    gap_hi = (ay0 * dxa + dya * (hi - ax0)) * dxb
                           - (by0 * dxb + dyb * (hi - bx0)) * dxa;
                    v.crossed = (gap_lo <= 0 && gap_hi >= 0) || (gap_lo >= 0 && gap_hi <= 0);
                end
            end
        end
        return v;
    endfunction

    function automatic void add_known(input int ax0, input int ay0, input int ax1,
                                      input int ay1, input int bx0, input int by0,
                                      input int bx1, input int by1, input bit crossed,
                                      input logic [2:0] decided_by);
        probe_row_t r;
        r.pair    = {CW'(ax0), CW'(ay0), CW'(ax1), CW'(ay1),
                     CW'(bx0), CW'(by0), CW'(bx1), CW'(by1)};
        r.known   = 1'b1;
        r.verdict = {crossed, decided_by};
        probe_table.push_back(r);
    endfunction

    function automatic void add_open(input int ax0, input int ay0, input int ax1,
                                     input int ay1, input int bx0, input int by0,
                                     input int bx1, input int by1);
        probe_row_t r;
        r.pair    = {CW'(ax0), CW'(ay0), CW'(ax1), CW'(ay1),
                     CW'(bx0), CW'(by0), CW'(bx1), CW'(by1)};
        r.known   = 1'b0;
        r.verdict = judge_segments(r.pair);
        probe_table.push_back(r);
    endfunction

    function automatic int pick_coord(input int span);
        if (span == 0)
            return $signed(CW'($urandom));
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Draw a pair, weighted towards verticals, parallels, touches and extremes
    function automatic sct_in_t random_pair();
        int kind, span, dx, dy, k;
        int c[8];
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 1) != 0) ? 64 : 1000;
        for (int i = 0; i < 8; i++)
            c[i] = (kind <= 1) ? pick_coord(0) : pick_coord(span);
        case (kind)
            4: begin
                c[2] = c[0];
            end
            5: begin
                c[6] = c[4];
            end
            6: begin
                dx   = int'($urandom_range(0, 40)) - 20;
                dy   = int'($urandom_range(0, 40)) - 20;
                k    = $urandom_range(1, 3);
                c[2] = c[0] + dx;
                c[3] = c[1] + dy;
                c[6] = c[4] + k * dx;
                c[7] = c[5] + k * dy;
            end
            7: begin
                c[2] = c[0];
                c[3] = c[1];
                if ($urandom_range(0, 1) != 0) begin
                    c[6] = c[4];
                    c[7] = c[5];
                end
            end
            8: begin
                c[4] = c[2];
                c[5] = c[3];
            end
            9: begin
                for (int i = 0; i < 8; i++) begin
                    case ($urandom_range(0, 4))
                        0: c[i] = -32768;
                        1: c[i] = 32767;
                        2: c[i] = 0;
                        3: c[i] = -1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return {CW'(c[0]), CW'(c[1]), CW'(c[2]), CW'(c[3]),
                CW'(c[4]), CW'(c[5]), CW'(c[6]), CW'(c[7])};
    endfunction

    // Offer one pair in bursts with random gaps; record its verdict on acceptance
    task automatic send_pair(input sct_in_t pair, input sct_out_t verdict);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= pair;
        do @(posedge aclk); while (!s_ready);
        pending_verdicts.push_back(verdict);
    endtask

    // Hold the sender until every outstanding verdict has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_verdicts.size() == 0);
        @(posedge aclk);
        burst_left = 0;
    endtask

    // Stall the receiver on a reloaded bit pattern, sometimes never stalling
    always @(posedge aclk) begin
        if (ready_index == '1) begin
            case ($urandom_range(0, 3))
                0: ready_pattern <= '1;
                1: ready_pattern <= $urandom;
                2: ready_pattern <= $urandom | $urandom;
                default: ready_pattern <= $urandom & $urandom;
            endcase
        end
        ready_index <= ready_index + 1'b1;
        m_ready     <= ready_pattern[ready_index];
    end

    // Check each accepted result against the oldest outstanding verdict
    always @(posedge aclk) begin
        sct_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch($sformatf("unexpected result crossed=%0b decided_by=%0d",
                                        m_data.crossed, m_data.decided_by));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_data.crossed !== want.crossed)
                    flag_mismatch($sformatf("crossed %0b, wanted %0b",
                                            m_data.crossed, want.crossed));
                if (m_data.decided_by !== want.decided_by)
                    flag_mismatch($sformatf("decided_by %0d, wanted %0d",
                                            m_data.decided_by, want.decided_by));
            end
        end
    end

    initial begin
        sct_in_t pair;

        // directed pairs: branches, touches and the coordinate extremes
        add_known(0, 0, 10, 0, 20, 0, 30, 5, 1'b0, DEC_DISJOINT);
        add_known(5, 0, 5, 10, 3, 0, 3, 10, 1'b0, DEC_BOTH_VERT);
        add_known(4, -2, 4, 9, 4, 0, 4, 20, 1'b0, DEC_BOTH_VERT);
        add_known(0, -10, 0, 10, -5, 0, 5, 0, 1'b1, DEC_A_VERT);
        add_known(0, 5, 0, 10, -5, 0, 5, 0, 1'b0, DEC_A_VERT);
        add_known(-5, 0, 5, 0, 0, -10, 0, 10, 1'b1, DEC_B_VERT);
        add_known(3, 3, 3, 3, 0, 0, 6, 6, 1'b1, DEC_A_VERT);
        add_known(0, 0, 10, 10, 0, 1, 10, 11, 1'b0, DEC_PARALLEL);
        add_known(0, 0, 10, 10, 5, 5, 15, 15, 1'b0, DEC_PARALLEL);
        add_known(0, 0, 10, 10, 0, 10, 10, 0, 1'b1, DEC_GENERAL);
        add_known(0, 0, 10, 10, 10, 10, 20, 0, 1'b1, DEC_GENERAL);
        add_known(0, 0, 10, 0, 0, 5, 10, 6, 1'b0, DEC_GENERAL);
        add_known(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                  1'b1, DEC_GENERAL);
        add_known(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                  1'b0, DEC_BOTH_VERT);
        add_known(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                  1'b0, DEC_BOTH_VERT);
        add_known(0, -32768, 0, 32767, -32768, -32768, 32767, 32767, 1'b1, DEC_A_VERT);
        add_known(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767,
                  1'b0, DEC_DISJOINT);
        add_open(10, 10, 0, 0, 10, 0, 0, 10);
        add_open(20, 0, 30, 5, 0, 0, 10, 0);
        add_open(0, 0, 10, 5, 10, -5, 10, 5);
        add_open(11, 0, 11, 5, 0, 0, 10, 10);
        add_open(7, 7, 7, 7, 7, 7, 7, 7);
        add_open(32767, -32768, 32767, 32767, -32768, 0, 32767, -1);

        // hold reset, then release it
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (probe_table[i])
            send_pair(probe_table[i].pair, probe_table[i].verdict);
        drain_results();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == RANDOM_PAIRS / 2)
                drain_results();
            pair = random_pair();
            send_pair(pair, judge_segments(pair));
        end
        s_valid <= 1'b0;

        // let the pipeline empty, then watch for strays
        wait (pending_verdicts.size() == 0);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS segment_crossing_test_unit");
        end else begin
            $display("FAIL segment_crossing_test_unit");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #5ms;
        $display("FAIL segment_crossing_test_unit");
        $finish;
    end

endmodule
